@@ rtl/bitmap_font_text_console_macros.svh @@
// Assertion macros for the bitmap font text console.
`ifndef BITMAP_FONT_TEXT_CONSOLE_MACROS_SVH
`define BITMAP_FONT_TEXT_CONSOLE_MACROS_SVH

`ifndef SYNTH
`define BFTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BFTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFTC_ASSERT_IMPL(lbl, ante, cons, msg)
`define BFTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/bftc_pkg.sv @@
// Types and constants of the bitmap font text console.
package bftc_pkg;

  localparam int AddrW   = 48;
  localparam int PitchW  = 14;
  localparam int ColW    = 13;
  localparam int LineW   = 12;
  localparam int ColourW = 32;
  localparam int CodeW   = 8;
  localparam int RowIdxW = 4;
  localparam int PosW    = 12;
  localparam int CfgIdxW = 3;

  localparam int CellRows = 16;
  localparam logic [ColW-1:0]    CellWidth = 13'd8;
  localparam logic [LineW-1:0]   LineStep  = 12'd16;
  localparam logic [LineW-1:0]   LineMax   = 12'hFFF;
  localparam logic [7:0]         FullMask  = 8'b1000_0000 | 8'h7F;
  localparam logic [ColourW-1:0] InkReset  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_PUT     = 3'd1,
    OP_BACK    = 3'd2,
    OP_NEWLINE = 3'd3,
    OP_DRAW    = 3'd4
  } bftc_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_BASE   = 3'd0,
    CFG_LINE_PITCH   = 3'd1,
    CFG_SCREEN_WIDTH = 3'd2,
    CFG_INK_COLOUR   = 3'd3,
    CFG_PAPER_COLOUR = 3'd4
  } bftc_cfg_e;

endpackage

@@ rtl/bitmap_font_text_console.sv @@
// Text console character generator with glyph memory and cursor.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data | in
//  in      | in_valid_i in_ready_o opcode..pos_y      | in
//  out     | out_valid_o out_ready_i write_address..  | out
//
// A glyph load, newline or unknown opcode is handled at the accept and does not leave idle.
// Put, draw and backspace step through the accept, one multiply for the line
// offset, one address add, then 16 row writes, one per cycle while the output is
// not stalled, from the glyph memory read port (registered, one row prefetched).
// Reset clears the cursor and registers (ink colour resets to all ones); the glyph memory is not cleared.
// A stalled output register holds the row; the prefetch stage holds behind it.
`include "bitmap_font_text_console_macros.svh"

module bitmap_font_text_console
  import bftc_pkg::*;
#(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [CodeW-1:0]   char_code_i,
  input  logic [RowIdxW-1:0] row_index_i,
  input  logic [7:0]         row_bits_i,
  input  logic [PosW-1:0]    pos_x_i,
  input  logic [PosW-1:0]    pos_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AddrW-1:0]   write_address_o,
  output logic [7:0]         pixel_mask_o,
  output logic [ColourW-1:0] pixel_colour_o,
  output logic               last_row_o
);

  localparam int Depth = GLYPH_COUNT * GLYPH_ROWS;
  localparam int MemAw = $clog2(Depth);
  localparam int GlyW  = $clog2(GLYPH_COUNT);
  localparam int CmpW  = $clog2(GLYPH_COUNT) + 2;
  localparam int CntW  = $clog2(CellRows) + 1;
  localparam int KW    = $clog2(CellRows);
  localparam int ProdW = LineW + PitchW;
  localparam int SumW  = ProdW + 1;
  localparam logic [KW-1:0] LastRow = KW'(CellRows - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADDR, S_EMIT} state_e;

  state_e state_q;

  logic [AddrW-1:0]   frame_base_q;
  logic [PitchW-1:0]  line_pitch_q;
  logic [ColW-1:0]    screen_width_q;
  logic [ColourW-1:0] ink_colour_q;
  logic [ColourW-1:0] paper_colour_q;

  logic [ColW-1:0]  cursor_col_q, cursor_col_d;
  logic [LineW-1:0] cursor_line_q, cursor_line_d;

  logic [ColW-1:0]    x_q, x_d;
  logic [LineW-1:0]   y_q, y_d;
  logic [ProdW-1:0]   prod_q;
  logic [AddrW-1:0]   addr_q;
  logic               is_bs_q;
  logic [7:0]         bs_mask_q, bs_mask_d;
  logic [MemAw-1:0]   gbase_q, gbase_d;
  logic [CntW-1:0]    rd_cnt_q;
  logic [KW-1:0]      emit_k_q;
  logic               dvld_q;

  logic               out_valid_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [7:0]         out_mask_q;
  logic [ColourW-1:0] out_colour_q;
  logic               out_last_q;

  logic [7:0]       glyph_mem [Depth];
  logic [7:0]       mem_rdata_q;
  logic             mem_we, mem_re;
  logic [MemAw-1:0] mem_waddr, mem_raddr;

  logic             in_fire, slot_free, consume, rd_issue, emit_op;
  logic [CmpW-1:0]  code_w, code_mod_w;
  logic [ColW-1:0]  pre_col;
  logic [LineW-1:0] pre_line;
  logic [ColW:0]    put_end;
  logic [SumW-1:0]  offset;
  bftc_op_e         op;

  function automatic logic [LineW-1:0] line_up(logic [LineW-1:0] l);
    return (l >= LineStep) ? l - LineStep : '0;
  endfunction

  function automatic logic [LineW-1:0] line_down(logic [LineW-1:0] l);
    logic [LineW:0] s;
    s = {1'b0, l} + {1'b0, LineStep};
    return (s > {1'b0, LineMax}) ? LineMax : s[LineW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign op          = bftc_op_e'(opcode_i);

  assign code_w     = CmpW'(char_code_i);
  assign code_mod_w = (code_w >= CmpW'(GLYPH_COUNT)) ? code_w - CmpW'(GLYPH_COUNT) : code_w;
  assign gbase_d    = MemAw'(MemAw'(code_mod_w[GlyW-1:0]) * MemAw'(GLYPH_ROWS));
  assign mem_waddr  = gbase_d + MemAw'(row_index_i);
  assign mem_we     = in_fire && (op == OP_LOAD) && (32'(row_index_i) < GLYPH_ROWS);

  assign slot_free = !out_valid_q || out_ready_i;
  assign consume   = (state_q == S_EMIT) && dvld_q && slot_free;
  assign rd_issue  = (state_q == S_EMIT) && (rd_cnt_q < CntW'(CellRows)) && (!dvld_q || consume);
  assign mem_raddr = gbase_q + MemAw'(rd_cnt_q[KW-1:0]);
  assign mem_re    = rd_issue && !is_bs_q && (32'(rd_cnt_q) < GLYPH_ROWS);

  assign put_end = {1'b0, cursor_col_q} + {1'b0, CellWidth} + {1'b0, CellWidth};
  assign offset  = SumW'(x_q) + SumW'(prod_q);

  always_comb begin
    pre_col       = (cursor_col_q == '0) ? screen_width_q : cursor_col_q;
    pre_line      = (cursor_col_q == '0) ? line_up(cursor_line_q) : cursor_line_q;
    cursor_col_d  = cursor_col_q;
    cursor_line_d = cursor_line_q;
    x_d           = cursor_col_q;
    y_d           = cursor_line_q;
    bs_mask_d     = FullMask;
    emit_op       = 1'b0;
    case (op)
      OP_PUT: begin
        emit_op = 1'b1;
        if (put_end > {1'b0, screen_width_q}) begin
          cursor_col_d  = '0;
          cursor_line_d = line_down(cursor_line_q);
        end else begin
          cursor_col_d = cursor_col_q + CellWidth;
        end
      end
      OP_BACK: begin
        emit_op = 1'b1;
        y_d     = pre_line;
        if (pre_col >= CellWidth) begin
          x_d           = pre_col - CellWidth;
          cursor_col_d  = pre_col - CellWidth;
          cursor_line_d = pre_line;
        end else begin
          x_d           = '0;
          bs_mask_d     = ~(FullMask >> pre_col[2:0]);
          cursor_col_d  = screen_width_q;
          cursor_line_d = line_up(pre_line);
        end
      end
      OP_NEWLINE: begin
        cursor_col_d  = '0;
        cursor_line_d = line_down(cursor_line_q);
      end
      OP_DRAW: begin
        emit_op = 1'b1;
        x_d     = ColW'(pos_x_i);
        y_d     = pos_y_i;
      end
      default: begin
        emit_op = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[mem_waddr] <= row_bits_i;
    end
    if (mem_re) begin
      mem_rdata_q <= glyph_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      frame_base_q   <= '0;
      line_pitch_q   <= '0;
      screen_width_q <= '0;
      ink_colour_q   <= InkReset;
      paper_colour_q <= '0;
      cursor_col_q   <= '0;
      cursor_line_q  <= '0;
      x_q            <= '0;
      y_q            <= '0;
      prod_q         <= '0;
      addr_q         <= '0;
      is_bs_q        <= 1'b0;
      bs_mask_q      <= '0;
      gbase_q        <= '0;
      rd_cnt_q       <= '0;
      emit_k_q       <= '0;
      dvld_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      out_addr_q     <= '0;
      out_mask_q     <= '0;
      out_colour_q   <= '0;
      out_last_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (bftc_cfg_e'(cfg_index_i))
          CFG_FRAME_BASE:   frame_base_q   <= cfg_data_i;
          CFG_LINE_PITCH:   line_pitch_q   <= cfg_data_i[PitchW-1:0];
          CFG_SCREEN_WIDTH: screen_width_q <= cfg_data_i[ColW-1:0];
          CFG_INK_COLOUR:   ink_colour_q   <= cfg_data_i[ColourW-1:0];
          CFG_PAPER_COLOUR: paper_colour_q <= cfg_data_i[ColourW-1:0];
          default: begin
            frame_base_q <= frame_base_q;
          end
        endcase
      end

      if (consume) begin
        out_valid_q  <= 1'b1;
        out_addr_q   <= addr_q;
        out_mask_q   <= is_bs_q ? bs_mask_q :
                        ((32'(emit_k_q) < GLYPH_ROWS) ? mem_rdata_q : '0);
        out_colour_q <= is_bs_q ? paper_colour_q : ink_colour_q;
        out_last_q   <= (emit_k_q == LastRow);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cursor_col_q  <= cursor_col_d;
            cursor_line_q <= cursor_line_d;
            x_q           <= x_d;
            y_q           <= y_d;
            is_bs_q       <= (op == OP_BACK);
            bs_mask_q     <= bs_mask_d;
            gbase_q       <= gbase_d;
            rd_cnt_q      <= '0;
            emit_k_q      <= '0;
            dvld_q        <= 1'b0;
            if (emit_op) begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= y_q * line_pitch_q;
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          addr_q  <= frame_base_q + AddrW'({offset, 2'b00});
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (rd_issue) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
            dvld_q   <= 1'b1;
          end else if (consume) begin
            dvld_q <= 1'b0;
          end
          if (consume) begin
            emit_k_q <= emit_k_q + 1'b1;
            addr_q   <= addr_q + AddrW'({line_pitch_q, 2'b00});
            if (emit_k_q == LastRow) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = out_addr_q;
  assign pixel_mask_o    = out_mask_q;
  assign pixel_colour_o  = out_colour_q;
  assign last_row_o      = out_last_q;

  `BFTC_ASSERT_IMPL(a_no_prefetch_outside_emit, state_q != S_EMIT, !dvld_q, "row data held outside emit")
  `BFTC_ASSERT_IMPL(a_read_count_tracks_emit, state_q == S_EMIT, CntW'(emit_k_q) + CntW'(dvld_q) == rd_cnt_q, "read count out of step with emitted rows")
  `BFTC_ASSERT_NEXT(a_last_row_ends_cell, consume && emit_k_q == LastRow, state_q == S_IDLE && out_valid_q && out_last_q, "cell did not end on its last row")
  `BFTC_ASSERT_IMPL(a_no_accept_while_busy, state_q != S_IDLE, !in_ready_o, "transaction accepted while a cell is in flight")

endmodule
